/* sv/assert_macros.svh */
// Assertion macros for the RTL of the sample average gamma pack block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge while reset is low.
`define SAGP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: property check failed");

// Checks that a condition never holds at a rising clock edge while reset is low.
`define SAGP_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");

`endif

/* sv/sagp_pkg.sv */
// Shared constants and types of the sample average gamma pack block.
`default_nettype none

package sagp_pkg;

   localparam int unsigned SUM_W        = 27;
   localparam int unsigned CHAN_W       = 8;
   localparam int unsigned SPP_W        = 11;
   localparam int unsigned PIXEL_W      = 24;
   localparam int unsigned NUM_CHANNELS = 3;

   localparam int unsigned MAX_SAMPLES_DEFAULT = 1024;
   localparam logic [SPP_W-1:0] SPP_RESET = 11'd100;

   // Channel slots inside a pixel state.
   localparam int unsigned CH_RED   = 2;
   localparam int unsigned CH_GREEN = 1;
   localparam int unsigned CH_BLUE  = 0;

   // Per-channel state of the square root search. root_sq_n holds root*root*n
   // and root_n holds root*n; both never exceed the sum, so they fit its width.
   typedef struct packed {
      logic [SUM_W-1:0]  sum;
      logic [SUM_W-1:0]  root_sq_n;
      logic [SUM_W-1:0]  root_n;
      logic [CHAN_W-1:0] root;
   } chan_type;

   typedef chan_type [NUM_CHANNELS-1:0] pix_state_type;

endpackage

`default_nettype wire

/* sv/sagp_channels_if.sv */
// Channel interfaces of the sample average gamma pack block.
`default_nettype none

interface sagp_req_if;
   logic                         valid;
   logic                         ready;
   logic [sagp_pkg::SUM_W-1:0]   red_sum;
   logic [sagp_pkg::SUM_W-1:0]   green_sum;
   logic [sagp_pkg::SUM_W-1:0]   blue_sum;
   modport source (output valid, output red_sum, output green_sum, output blue_sum,
                   input ready);
   modport sink   (input valid, input red_sum, input green_sum, input blue_sum,
                   output ready);
endinterface

interface sagp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sagp_pkg::PIXEL_W-1:0] packed_pixel;
   modport source (output valid, output packed_pixel, input ready);
   modport sink   (input valid, input packed_pixel, output ready);
endinterface

interface sagp_csr_if;
   logic                         valid;
   logic                         ready;
   logic [sagp_pkg::SPP_W-1:0]   data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/sample_average_gamma_pack_unit.sv */
// Top level of the sample average gamma pack block: averaging, gamma 2 and RGB888 packing.
//
//   Channel  Direction  Payload                           Handshake
//   req      in         red_sum, green_sum, blue_sum      valid / ready
//   rsp      out        packed_pixel (0xRRGGBB)           valid / ready
//   csr      in         data = samples_per_pixel          valid / ready (always ready)
//
// One request is accepted per cycle while rsp is not stalled, and it passes through ten
// register stages: one input stage, eight square root stages (one result bit each)
// and one output stage. The depth is set by the eight-bit bitwise root search.
// Reset is synchronous and clears only the stage valid bits and the sample
// count register, which returns to 100.
// Each stage holds its contents while the stage after it is full and stalled,
// so a stall on rsp backs up through the pipeline and empty stages still fill.
`default_nettype none

`include "assert_macros.svh"

module sample_average_gamma_pack_unit #(
   parameter int unsigned MAX_SAMPLES = sagp_pkg::MAX_SAMPLES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   sagp_req_if.sink          req,
   sagp_rsp_if.source        rsp,
   sagp_csr_if.sink          csr
);

   localparam int unsigned NW    = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned STEPS = sagp_pkg::CHAN_W;

   // Each channel value is min(255, floor(sqrt(floor(sum / n)))). That is the
   // largest r below 256 with r*r*n <= sum, which the stages find one bit at a
   // time from the top bit down, without ever dividing.

   logic                    stg_valid [STEPS+1];
   logic                    stg_ready [STEPS+1];
   sagp_pkg::pix_state_type stg_state [STEPS+1];
   logic [NW-1:0]           stg_n     [STEPS+1];
   logic [NW-1:0]           n_eff;
   logic                    csr_legal;

   sagp_csr #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr.valid),
      .csr_ready (csr.ready),
      .csr_data  (csr.data),
      .n_eff     (n_eff)
   );

   // The sample count is captured with each request as it enters.
   sagp_entry #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_entry (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .red_sum   (req.red_sum),
      .green_sum (req.green_sum),
      .blue_sum  (req.blue_sum),
      .n_eff     (n_eff),
      .dn_valid  (stg_valid[0]),
      .dn_ready  (stg_ready[0]),
      .dn_state  (stg_state[0]),
      .dn_n      (stg_n[0])
   );

   for (genvar g = 0; g < STEPS; g++) begin : g_step
      sagp_root_step #(
         .MAX_SAMPLES (MAX_SAMPLES),
         .BIT         (STEPS - 1 - g)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stg_valid[g]),
         .up_ready (stg_ready[g]),
         .up_state (stg_state[g]),
         .up_n     (stg_n[g]),
         .dn_valid (stg_valid[g+1]),
         .dn_ready (stg_ready[g+1]),
         .dn_state (stg_state[g+1]),
         .dn_n     (stg_n[g+1])
      );
   end

   sagp_pack_out u_pack (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (stg_valid[STEPS]),
      .up_ready     (stg_ready[STEPS]),
      .up_state     (stg_state[STEPS]),
      .rsp_valid    (rsp.valid),
      .rsp_ready    (rsp.ready),
      .packed_pixel (rsp.packed_pixel)
   );

   // A write on the csr port that carries a count inside the legal range.
   assign csr_legal = csr.valid && csr.ready && (csr.data != '0) &&
                      (32'(csr.data) <= 32'(MAX_SAMPLES));

   // The effective sample count is never zero and never beyond the limit.
   `SAGP_NEVER(a_n_range, clock, reset, (n_eff == '0) || (32'(n_eff) > 32'(MAX_SAMPLES)))

   // A legal count written on the csr port is used from the next cycle on.
   `SAGP_ASSERT(a_csr_applied, clock, reset, csr_legal |=> (32'(n_eff) == 32'($past(csr.data))))

   // With the output register empty, every stage can move, so a request is taken.
   `SAGP_ASSERT(a_ready_when_drained, clock, reset, !rsp.valid |-> req.ready)

   // A pixel taken with nothing behind it leaves the output empty.
   `SAGP_ASSERT(a_out_drains, clock, reset, (rsp.valid && rsp.ready && !stg_valid[STEPS]) |=> !rsp.valid)

endmodule

`default_nettype wire

/* sv/sagp_csr.sv */
// Sample count register and its clamp to the legal divisor range.
`default_nettype none

module sagp_csr #(
   parameter int unsigned MAX_SAMPLES = sagp_pkg::MAX_SAMPLES_DEFAULT,
   localparam int unsigned NW = $clog2(MAX_SAMPLES + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [sagp_pkg::SPP_W-1:0] csr_data,
   output logic [NW-1:0]              n_eff
);

   logic [sagp_pkg::SPP_W-1:0] spp_ff;
   logic [31:0]                spp_ext;
   logic [31:0]                n_wide;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spp_ff <= sagp_pkg::SPP_RESET;
      end else if (csr_valid) begin
         spp_ff <= csr_data;
      end
   end

   // A count of zero acts as one; a count above the limit saturates.
   always_comb begin
      spp_ext = 32'(spp_ff);
      if (spp_ext == 32'd0) begin
         n_wide = 32'd1;
      end else if (spp_ext > 32'(MAX_SAMPLES)) begin
         n_wide = 32'(MAX_SAMPLES);
      end else begin
         n_wide = spp_ext;
      end
   end

   assign n_eff = n_wide[NW-1:0];

endmodule

`default_nettype wire

/* sv/sagp_entry.sv */
// Input stage: registers the channel sums together with the sample count.
`default_nettype none

module sagp_entry #(
   parameter int unsigned MAX_SAMPLES = sagp_pkg::MAX_SAMPLES_DEFAULT,
   localparam int unsigned NW = $clog2(MAX_SAMPLES + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [sagp_pkg::SUM_W-1:0] red_sum,
   input  logic [sagp_pkg::SUM_W-1:0] green_sum,
   input  logic [sagp_pkg::SUM_W-1:0] blue_sum,
   input  logic [NW-1:0]              n_eff,
   output logic                       dn_valid,
   input  logic                       dn_ready,
   output sagp_pkg::pix_state_type    dn_state,
   output logic [NW-1:0]              dn_n
);

   logic                    valid_ff;
   sagp_pkg::pix_state_type state_ff;
   sagp_pkg::pix_state_type state_in;
   logic [NW-1:0]           n_ff;

   // The search starts from root zero in every channel.
   always_comb begin
      state_in = '0;
      state_in[sagp_pkg::CH_RED].sum   = red_sum;
      state_in[sagp_pkg::CH_GREEN].sum = green_sum;
      state_in[sagp_pkg::CH_BLUE].sum  = blue_sum;
   end

   assign req_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         state_ff <= state_in;
         n_ff     <= n_eff;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_state = state_ff;
   assign dn_n     = n_ff;

endmodule

`default_nettype wire

/* sv/sagp_root_step.sv */
// One pipeline stage of the square root search: decides one result bit per channel.
`default_nettype none

module sagp_root_step #(
   parameter int unsigned MAX_SAMPLES = sagp_pkg::MAX_SAMPLES_DEFAULT,
   parameter int unsigned BIT         = 0,
   localparam int unsigned NW = $clog2(MAX_SAMPLES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   output logic                    up_ready,
   input  sagp_pkg::pix_state_type up_state,
   input  logic [NW-1:0]           up_n,
   output logic                    dn_valid,
   input  logic                    dn_ready,
   output sagp_pkg::pix_state_type dn_state,
   output logic [NW-1:0]           dn_n
);

   localparam int unsigned SW  = sagp_pkg::SUM_W;
   localparam int unsigned CW  = sagp_pkg::CHAN_W;
   localparam int unsigned NC  = sagp_pkg::NUM_CHANNELS;
   localparam int unsigned AW  = SW + BIT + 1;
   localparam int unsigned BW  = NW + 2 * BIT;
   localparam int unsigned TW  = ((AW > BW) ? AW : BW) + 2;
   localparam logic [CW-1:0] BIT_MASK = CW'(1) << BIT;

   logic                    valid_ff;
   sagp_pkg::pix_state_type state_ff;
   sagp_pkg::pix_state_type state_in;
   logic [NW-1:0]           n_ff;
   logic [TW-1:0]           trial [NC];
   logic [TW-1:0]           step_n [NC];

   // With root r and candidate bit 2^k, (r + 2^k)^2 * n is
   // r^2*n + 2^(k+1)*r*n + 2^(2k)*n, so only shifts and adds are needed.
   // The bit is kept when that product does not exceed the sum.
   always_comb begin
      state_in = up_state;
      for (int c = 0; c < NC; c++) begin
         trial[c]  = TW'(up_state[c].root_sq_n)
                   + (TW'(up_state[c].root_n) << (BIT + 1))
                   + (TW'(up_n) << (2 * BIT));
         step_n[c] = TW'(up_state[c].root_n) + (TW'(up_n) << BIT);
         if (trial[c] <= TW'(up_state[c].sum)) begin
            state_in[c].root      = up_state[c].root | BIT_MASK;
            state_in[c].root_sq_n = trial[c][SW-1:0];
            state_in[c].root_n    = step_n[c][SW-1:0];
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         state_ff <= state_in;
         n_ff     <= up_n;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_state = state_ff;
   assign dn_n     = n_ff;

endmodule

`default_nettype wire

/* sv/sagp_pack_out.sv */
// Output stage: packs the three channel roots into the pixel word.
`default_nettype none

module sagp_pack_out (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         up_valid,
   output logic                         up_ready,
   input  sagp_pkg::pix_state_type      up_state,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [sagp_pkg::PIXEL_W-1:0] packed_pixel
);

   logic                         valid_ff;
   logic [sagp_pkg::PIXEL_W-1:0] pixel_ff;
   logic [sagp_pkg::PIXEL_W-1:0] pixel_in;

   assign pixel_in = {up_state[sagp_pkg::CH_RED].root,
                      up_state[sagp_pkg::CH_GREEN].root,
                      up_state[sagp_pkg::CH_BLUE].root};

   assign up_ready = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         pixel_ff <= pixel_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign packed_pixel = pixel_ff;

endmodule

`default_nettype wire
